// ----- rtl/orot_pkg.sv -----
// Shared constants and the CORDIC arctangent table for the oriented
// rectangle overlap test. No dependencies.
package orot_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 33;          // 30 fraction bits plus sign and headroom
  localparam int ZW           = 32;          // residual angle width
  localparam int SC_W         = 16;          // sine/cosine, 14 fraction bits
  localparam int SC_SHIFT     = 16;          // 30 -> 14 fraction bits
  localparam int CORNER_SHIFT = 14;          // 12 -> 26 fraction bits
  localparam int TOL_SHIFT    = 28;          // 12 -> 40 fraction bits
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 33'sd32768;

  localparam int CORDIC_LAT = CORDIC_STEPS + 1;
  localparam int GEOM_LAT   = 2;
  localparam int SAT_LAT    = 5;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/orot_if.sv -----
// Valid/ready channel interfaces for the rectangle pair and the result.
// No dependencies.
interface orot_in_if #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic        [COORD_WIDTH-2:0] a_width;
  logic        [COORD_WIDTH-2:0] a_height;
  logic        [ANGLE_WIDTH-1:0] a_angle;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic        [COORD_WIDTH-2:0] b_width;
  logic        [COORD_WIDTH-2:0] b_height;
  logic        [ANGLE_WIDTH-1:0] b_angle;

  modport source (output valid, a_x, a_y, a_width, a_height, a_angle,
                  b_x, b_y, b_width, b_height, b_angle, input ready);
  modport sink   (input valid, a_x, a_y, a_width, a_height, a_angle,
                  b_x, b_y, b_width, b_height, b_angle, output ready);
endinterface

interface orot_out_if;
  logic valid;
  logic ready;
  logic collide;

  modport source (output valid, collide, input ready);
  modport sink   (input valid, collide, output ready);
endinterface

// ----- rtl/orot_cordic.sv -----
// Pipelined CORDIC: one rotation step per stage, then quadrant fold and rounding.
// Depends on orot_pkg.
module orot_cordic #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    adv,
  input  logic [ANGLE_WIDTH-1:0]                  angle,
  output logic signed [orot_pkg::SC_W-1:0]        cos_o,
  output logic signed [orot_pkg::SC_W-1:0]        sin_o
);
  localparam int STEPS = orot_pkg::CORDIC_STEPS;
  localparam int CW    = orot_pkg::CORDIC_W;
  localparam int ZW    = orot_pkg::ZW;

  typedef logic signed [CW-1:0] cv_t;
  typedef logic signed [ZW-1:0] zv_t;

  logic [31:0] phase;
  cv_t         x_r [STEPS];
  cv_t         y_r [STEPS];
  zv_t         z_r [STEPS];
  logic [1:0]  q_r [STEPS];
  cv_t         cc, ss, cr, sr;

  assign phase = {angle, {(32-ANGLE_WIDTH){1'b0}}};

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    cv_t        xi, yi;
    zv_t        zi;
    logic [1:0] qi;
    if (i == 0) begin : g_first
      assign xi = orot_pkg::CORDIC_X0;
      assign yi = '0;
      assign zi = zv_t'({2'b00, phase[29:0]});
      assign qi = phase[31:30];
    end else begin : g_rest
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign qi = q_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!zi[ZW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - zv_t'(orot_pkg::atan_turn(i));
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + zv_t'(orot_pkg::atan_turn(i));
        end
        q_r[i] <= qi;
      end
    end
  end

  // fold the first-quadrant result into the full turn
  always_comb begin
    case (q_r[STEPS-1])
      2'd0:    begin cc =  x_r[STEPS-1]; ss =  y_r[STEPS-1]; end
      2'd1:    begin cc = -y_r[STEPS-1]; ss =  x_r[STEPS-1]; end
      2'd2:    begin cc = -x_r[STEPS-1]; ss = -y_r[STEPS-1]; end
      default: begin cc =  y_r[STEPS-1]; ss = -x_r[STEPS-1]; end
    endcase
    cr = cc + orot_pkg::ROUND_HALF;
    sr = ss + orot_pkg::ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_o <= cr[orot_pkg::SC_SHIFT +: orot_pkg::SC_W];
      sin_o <= sr[orot_pkg::SC_SHIFT +: orot_pkg::SC_W];
    end
  end

endmodule

// ----- rtl/orot_geom.sv -----
// Vertex builder: rotated edge products, then corner sums (two stages).
// Depends on orot_pkg.
module orot_geom #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic signed [COORD_WIDTH-1:0]        px,
  input  logic signed [COORD_WIDTH-1:0]        py,
  input  logic        [COORD_WIDTH-2:0]        w,
  input  logic        [COORD_WIDTH-2:0]        h,
  input  logic signed [orot_pkg::SC_W-1:0]     c_i,
  input  logic signed [orot_pkg::SC_W-1:0]     s_i,
  output logic signed [COORD_WIDTH+15:0]       vx_o [4],
  output logic signed [COORD_WIDTH+15:0]       vy_o [4],
  output logic signed [orot_pkg::SC_W-1:0]     c_o,
  output logic signed [orot_pkg::SC_W-1:0]     s_o
);
  localparam int VW = COORD_WIDTH + 16;
  typedef logic signed [VW-1:0] vw_t;

  vw_t cw_r, sw_r, ch_r, sh_r, px_r, py_r;
  logic signed [orot_pkg::SC_W-1:0] c_r, s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      cw_r <= c_i * $signed({1'b0, w});
      sw_r <= s_i * $signed({1'b0, w});
      ch_r <= c_i * $signed({1'b0, h});
      sh_r <= s_i * $signed({1'b0, h});
      px_r <= vw_t'(px) <<< orot_pkg::CORNER_SHIFT;
      py_r <= vw_t'(py) <<< orot_pkg::CORNER_SHIFT;
      c_r  <= c_i;
      s_r  <= s_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_o[0] <= px_r;
      vy_o[0] <= py_r;
      vx_o[1] <= px_r + cw_r;
      vy_o[1] <= py_r + sw_r;
      vx_o[2] <= px_r + cw_r - sh_r;
      vy_o[2] <= py_r + sw_r + ch_r;
      vx_o[3] <= px_r - sh_r;
      vy_o[3] <= py_r + ch_r;
      c_o     <= c_r;
      s_o     <= s_r;
    end
  end

endmodule

// ----- rtl/orot_sat.sv -----
// Separating-axis check: projections, interval min/max tree, gap compare.
// Depends on orot_pkg.
module orot_sat #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              adv,
  input  logic signed [COORD_WIDTH+15:0]    va_x [4],
  input  logic signed [COORD_WIDTH+15:0]    va_y [4],
  input  logic signed [COORD_WIDTH+15:0]    vb_x [4],
  input  logic signed [COORD_WIDTH+15:0]    vb_y [4],
  input  logic signed [orot_pkg::SC_W-1:0]  ca,
  input  logic signed [orot_pkg::SC_W-1:0]  sa,
  input  logic signed [orot_pkg::SC_W-1:0]  cb,
  input  logic signed [orot_pkg::SC_W-1:0]  sb,
  input  logic        [COORD_WIDTH-2:0]     tol,
  output logic        [3:0]                 sep_o
);
  localparam int MW  = COORD_WIDTH + 32;
  localparam int PW  = COORD_WIDTH + 33;
  localparam int PW1 = PW + 1;
  typedef logic signed [MW-1:0]  mw_t;
  typedef logic signed [PW-1:0]  pw_t;
  typedef logic signed [PW1-1:0] pw1_t;

  logic signed [orot_pkg::SC_W-1:0] nx [4];
  logic signed [orot_pkg::SC_W-1:0] ny [4];
  logic signed [COORD_WIDTH+15:0]   vx [8];
  logic signed [COORD_WIDTH+15:0]   vy [8];

  mw_t  mx_r [4][8];
  mw_t  my_r [4][8];
  pw_t  p_r  [4][8];
  pw_t  lo2_r [4][4];
  pw_t  hi2_r [4][4];
  pw_t  lo_r [4][2];
  pw_t  hi_r [4][2];
  pw1_t tol_s;

  // first two outward normals of A, then of B
  assign nx[0] = sa;  assign ny[0] = -ca;
  assign nx[1] = ca;  assign ny[1] = sa;
  assign nx[2] = sb;  assign ny[2] = -cb;
  assign nx[3] = cb;  assign ny[3] = sb;

  for (genvar j = 0; j < 4; j++) begin : g_v
    assign vx[j]   = va_x[j];
    assign vy[j]   = va_y[j];
    assign vx[j+4] = vb_x[j];
    assign vy[j+4] = vb_y[j];
  end

  assign tol_s = pw1_t'($signed({1'b0, tol})) <<< orot_pkg::TOL_SHIFT;

  for (genvar k = 0; k < 4; k++) begin : g_ax
    for (genvar j = 0; j < 8; j++) begin : g_pt
      always_ff @(posedge clk) begin
        if (adv) begin
          mx_r[k][j] <= nx[k] * vx[j];
          my_r[k][j] <= ny[k] * vy[j];
          p_r[k][j]  <= pw_t'(mx_r[k][j]) + pw_t'(my_r[k][j]);
        end
      end
    end
    // pairwise min/max: pairs (0,1) (2,3) of A and (4,5) (6,7) of B
    for (genvar q = 0; q < 4; q++) begin : g_pair
      always_ff @(posedge clk) begin
        if (adv) begin
          lo2_r[k][q] <= (p_r[k][2*q] < p_r[k][2*q+1]) ? p_r[k][2*q] : p_r[k][2*q+1];
          hi2_r[k][q] <= (p_r[k][2*q] > p_r[k][2*q+1]) ? p_r[k][2*q] : p_r[k][2*q+1];
        end
      end
    end
    for (genvar r = 0; r < 2; r++) begin : g_rect
      always_ff @(posedge clk) begin
        if (adv) begin
          lo_r[k][r] <= (lo2_r[k][2*r] < lo2_r[k][2*r+1]) ? lo2_r[k][2*r] : lo2_r[k][2*r+1];
          hi_r[k][r] <= (hi2_r[k][2*r] > hi2_r[k][2*r+1]) ? hi2_r[k][2*r] : hi2_r[k][2*r+1];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sep_o[k] <= (pw1_t'(hi_r[k][0]) + tol_s < pw1_t'(lo_r[k][1])) ||
                    (pw1_t'(lo_r[k][0]) > pw1_t'(hi_r[k][1]) + tol_s);
      end
    end
  end

endmodule

// ----- rtl/oriented_rect_overlap_test_unit.sv -----
// Oriented rectangle overlap test (separating axis test) top level.
// An accepted input beat reaches its result beat through 31 CORDIC stages,
// 2 vertex stages, 5 projection/compare stages and the output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result waits.
// Reset (rst_n low, synchronous) clears all valid bits and the tolerance to 0.
// Depends on orot_pkg, orot_if, orot_cordic, orot_geom, orot_sat.
module oriented_rect_overlap_test_unit #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  orot_in_if.sink                in_if,
  orot_out_if.source             out_if,
  input  logic                   cfg_we,
  input  logic [COORD_WIDTH-2:0] cfg_wdata
);
  localparam int CLAT = orot_pkg::CORDIC_LAT;
  localparam int LAT  = orot_pkg::CORDIC_LAT + orot_pkg::GEOM_LAT + orot_pkg::SAT_LAT;
  localparam int VW   = COORD_WIDTH + 16;

  // corner and size fields ride alongside the CORDIC stages
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic        [COORD_WIDTH-2:0] aw;
    logic        [COORD_WIDTH-2:0] ah;
    logic        [COORD_WIDTH-2:0] bw;
    logic        [COORD_WIDTH-2:0] bh;
  } side_t;

  logic                   adv;
  logic [LAT-1:0]         v_r;
  logic                   out_valid_r;
  logic                   collide_r;
  logic [COORD_WIDTH-2:0] tol_r;
  side_t                  side_in;
  side_t                  side_r [CLAT];

  logic signed [orot_pkg::SC_W-1:0] ca, sa, cb, sb;
  logic signed [orot_pkg::SC_W-1:0] ca_g, sa_g, cb_g, sb_g;
  logic signed [VW-1:0] va_x [4];
  logic signed [VW-1:0] va_y [4];
  logic signed [VW-1:0] vb_x [4];
  logic signed [VW-1:0] vb_y [4];
  logic [3:0]           sep;

  // advance everything whenever the output register is free or being drained
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  assign out_if.valid   = out_valid_r;
  assign out_if.collide = collide_r;

  assign side_in = '{ax: in_if.a_x, ay: in_if.a_y, bx: in_if.b_x, by: in_if.b_y,
                     aw: in_if.a_width, ah: in_if.a_height,
                     bw: in_if.b_width, bh: in_if.b_height};

  // tolerance register; the user must write it only while the pipeline is empty (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // valid line follows the data stage by stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[LAT-2:0], in_if.valid};
      out_valid_r <= v_r[LAT-1];
    end
  end

  // delay the corner and size fields to meet the sine/cosine outputs
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_in;
      for (int i = 1; i < CLAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  orot_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_a (
    .clk(clk), .adv(adv), .angle(in_if.a_angle), .cos_o(ca), .sin_o(sa)
  );

  orot_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_b (
    .clk(clk), .adv(adv), .angle(in_if.b_angle), .cos_o(cb), .sin_o(sb)
  );

  orot_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom_a (
    .clk(clk), .adv(adv),
    .px(side_r[CLAT-1].ax), .py(side_r[CLAT-1].ay),
    .w(side_r[CLAT-1].aw), .h(side_r[CLAT-1].ah),
    .c_i(ca), .s_i(sa),
    .vx_o(va_x), .vy_o(va_y), .c_o(ca_g), .s_o(sa_g)
  );

  orot_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom_b (
    .clk(clk), .adv(adv),
    .px(side_r[CLAT-1].bx), .py(side_r[CLAT-1].by),
    .w(side_r[CLAT-1].bw), .h(side_r[CLAT-1].bh),
    .c_i(cb), .s_i(sb),
    .vx_o(vb_x), .vy_o(vb_y), .c_o(cb_g), .s_o(sb_g)
  );

  orot_sat #(.COORD_WIDTH(COORD_WIDTH)) u_sat (
    .clk(clk), .adv(adv),
    .va_x(va_x), .va_y(va_y), .vb_x(vb_x), .vb_y(vb_y),
    .ca(ca_g), .sa(sa_g), .cb(cb_g), .sb(sb_g),
    .tol(tol_r), .sep_o(sep)
  );

  // collide unless some axis separates the pair
  always_ff @(posedge clk) begin
    if (adv) begin
      collide_r <= ~|sep;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds_line: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("valid line moved during a stall");

  a_ready_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |-> !in_if.ready)
    else $error("input taken while the result beat is blocked");

  a_out_from_line: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v_r[LAT-1]))
    else $error("result beat appeared without a pipeline item");
`endif

endmodule

// ----- test/orot_tb_if.sv -----
// Testbench-side note: the channel interfaces come from rtl/orot_if.sv.
// This file holds the small shared parameter package for the testbench.
// No dependencies.
`timescale 1ns / 1ps
package orot_tb_pkg;
  localparam int CW = 24;
  localparam int AW = 16;
  localparam int PIPE_LAT = 39;
endpackage

// ----- test/orot_checker.sv -----
// Collision predictor and result scoreboard for the rectangle overlap unit.
// Watches the input, output and config ports. Depends on orot_if, orot_tb_pkg.
`timescale 1ns / 1ps
module orot_checker (
  input  logic         clk,
  input  logic         rst_n,
  orot_in_if           in_if,
  orot_out_if          out_if,
  input  logic         cfg_we,
  input  logic [22:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);

  localparam longint ATAN [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  typedef struct {
    longint vx[4];
    longint vy[4];
    longint nx[2];
    longint ny[2];
  } rect_geom_t;

  logic [22:0] tol_reg;
  // expected flags in arrival order, far deeper than the pipeline
  bit          exp_ring [1024];
  int          wr_cnt;
  int          rd_cnt;

  function automatic void rotate_unit(input logic [orot_tb_pkg::AW-1:0] ang,
                                      output longint c, output longint s);
    logic [31:0] ph;
    longint x, y, z, t, dx, dy, cc, ss;
    ph = {ang, 16'd0};
    z = longint'(ph[29:0]);
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        t = x - dx; y = y + dy; z = z - ATAN[i];
      end else begin
        t = x + dx; y = y - dy; z = z + ATAN[i];
      end
      x = t;
    end
    case (ph[31:30])
      2'd0: begin cc = x;  ss = y;  end
      2'd1: begin cc = -y; ss = x;  end
      2'd2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = (cc + 32768) >>> 16;
    s = (ss + 32768) >>> 16;
  endfunction

  function automatic rect_geom_t place_rect(
      input logic signed [orot_tb_pkg::CW-1:0] px0, py0,
      input logic [orot_tb_pkg::CW-2:0] w0, h0,
      input logic [orot_tb_pkg::AW-1:0] ang);
    rect_geom_t r;
    longint px, py, w, h, c, s;
    px = longint'(px0) * 16384;
    py = longint'(py0) * 16384;
    w = longint'(w0);
    h = longint'(h0);
    rotate_unit(ang, c, s);
    r.vx[0] = px;                 r.vy[0] = py;
    r.vx[1] = px + c * w;         r.vy[1] = py + s * w;
    r.vx[2] = px + c * w - s * h; r.vy[2] = py + s * w + c * h;
    r.vx[3] = px - s * h;         r.vy[3] = py + c * h;
    r.nx[0] = s; r.ny[0] = -c;
    r.nx[1] = c; r.ny[1] = s;
    return r;
  endfunction

  function automatic void span(input rect_geom_t r, input longint nx, ny,
                               output longint lo, hi);
    longint p;
    for (int k = 0; k < 4; k++) begin
      p = nx * r.vx[k] + ny * r.vy[k];
      if (k == 0 || p < lo) lo = p;
      if (k == 0 || p > hi) hi = p;
    end
  endfunction

  function automatic bit rects_collide();
    rect_geom_t ra, rb, src;
    longint tol, lo1, hi1, lo2, hi2;
    bit hit;
    ra = place_rect(in_if.a_x, in_if.a_y, in_if.a_width, in_if.a_height, in_if.a_angle);
    rb = place_rect(in_if.b_x, in_if.b_y, in_if.b_width, in_if.b_height, in_if.b_angle);
    tol = longint'(tol_reg) <<< 28;
    hit = 1'b1;
    for (int k = 0; k < 4; k++) begin
      src = (k < 2) ? ra : rb;
      span(ra, src.nx[k % 2], src.ny[k % 2], lo1, hi1);
      span(rb, src.nx[k % 2], src.ny[k % 2], lo2, hi2);
      if (hi1 + tol < lo2 || lo1 > hi2 + tol) hit = 1'b0;
    end
    return hit;
  endfunction

  assign pending = wr_cnt - rd_cnt;

  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      tol_reg <= '0;
      fail_count <= 0;
      wr_cnt <= 0;
      rd_cnt <= 0;
    end else begin
      if (cfg_we) tol_reg <= cfg_wdata;
      if (in_if.valid && in_if.ready) begin
        exp_ring[wr_cnt[9:0]] <= rects_collide();
        wr_cnt <= wr_cnt + 1;
      end
      if (out_if.valid && out_if.ready) begin
        if (wr_cnt == rd_cnt) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat collide=%0b", out_if.collide);
        end else begin
          want = exp_ring[rd_cnt[9:0]];
          rd_cnt <= rd_cnt + 1;
          if (out_if.collide !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("collide mismatch: expected %0b got %0b", want, out_if.collide);
          end
        end
      end
    end
  end
endmodule

// ----- test/testbench.sv -----
// Top of the rectangle overlap test bench: clock, reset, stimulus, verdict.
// Depends on orot_pkg, orot_if, orot_tb_pkg, orot_checker and the unit.
`timescale 1ns / 1ps
module testbench;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [22:0] cfg_wdata;
  int          fail_count;
  int          pending;
  longint      cycles;

  orot_in_if  #(.COORD_WIDTH(orot_tb_pkg::CW), .ANGLE_WIDTH(orot_tb_pkg::AW)) in_if ();
  orot_out_if out_if ();

  oriented_rect_overlap_test_unit #(
    .COORD_WIDTH(orot_tb_pkg::CW), .ANGLE_WIDTH(orot_tb_pkg::AW)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  orot_checker chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall ready for a random count of cycles per beat.
  // Stall-free stretches come from the sender setting quiet_sink.
  bit quiet_sink;
  initial begin
    int gap;
    forever begin
      gap = quiet_sink ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // hold ready until the beat is taken, then redraw
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Watchdog: generous cycle limit covering full stalls on both sides.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("oriented_rect_overlap_test_unit verification failed");
        $finish;
      end
    end
  end

  // Hold the input beat until accepted; idle a random count beforehand unless no_gap is set.
  task automatic send_pair(input logic [23:0] ax, ay, input logic [22:0] aw, ah,
                           input logic [15:0] aa, input logic [23:0] bx, by,
                           input logic [22:0] bw, bh, input logic [15:0] ba,
                           input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.a_x <= ax; in_if.a_y <= ay; in_if.a_width <= aw; in_if.a_height <= ah;
    in_if.a_angle <= aa; in_if.b_x <= bx; in_if.b_y <= by; in_if.b_width <= bw;
    in_if.b_height <= bh; in_if.b_angle <= ba;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drop valid and wait until every expected result is back, then let the
  // pipeline drain so a config write never lands on work in flight.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (orot_tb_pkg::PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic write_tol(input logic [22:0] v);
    @(posedge clk) begin
      cfg_we <= 1'b1;
      cfg_wdata <= v;
    end
    @(posedge clk) cfg_we <= 1'b0;
  endtask

  // Random pair biased toward near-overlap: small sizes, nearby corners, with
  // occasional full-range extremes.
  task automatic random_pair(input bit no_gap);
    logic [23:0] ax, ay, bx, by;
    logic [22:0] aw, ah, bw, bh;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      ax = 24'($signed($urandom_range(0, 40000)) - 20000);
      ay = 24'($signed($urandom_range(0, 40000)) - 20000);
      bx = ax + 24'($signed($urandom_range(0, 60000)) - 30000);
      by = ay + 24'($signed($urandom_range(0, 60000)) - 30000);
      aw = 23'($urandom_range(0, 30000)); ah = 23'($urandom_range(0, 30000));
      bw = 23'($urandom_range(0, 30000)); bh = 23'($urandom_range(0, 30000));
    end else begin
      ax = 24'($urandom); ay = 24'($urandom); bx = 24'($urandom); by = 24'($urandom);
      aw = 23'($urandom); ah = 23'($urandom); bw = 23'($urandom); bh = 23'($urandom);
    end
    send_pair(ax, ay, aw, ah, 16'($urandom), bx, by, bw, bh, 16'($urandom), no_gap);
  endtask

  initial begin
    logic [22:0] tol_set [4];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    quiet_sink = 1'b0;
    in_if.valid = 1'b0;
    {in_if.a_x, in_if.a_y, in_if.a_width, in_if.a_height, in_if.a_angle} = '0;
    {in_if.b_x, in_if.b_y, in_if.b_width, in_if.b_height, in_if.b_angle} = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, zero sizes, quadrant angles, touching edges.
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF,
              24'h800000, 24'h800000, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF, 0);
    send_pair(24'h800000, 24'h7FFFFF, 23'h7FFFFF, 0, 16'h4000,
              24'h7FFFFF, 24'h800000, 0, 23'h7FFFFF, 16'hC000, 0);
    send_pair(0, 0, 4096, 4096, 0, 4096, 0, 4096, 4096, 0, 0);
    send_pair(0, 0, 4096, 4096, 0, 4097, 0, 4096, 4096, 0, 0);
    send_pair(0, 0, 8192, 4096, 16'h2000, 100, 100, 4096, 8192, 16'h8000, 0);
    send_pair(24'hFFF000, 24'hFFF000, 100, 100, 16'h4000, 0, 0, 0, 0, 16'hC000, 0);
    send_pair(0, 0, 4096, 4096, 16'h0001, 8192, 8192, 4096, 4096, 16'h7FFF, 0);
    send_pair(24'h555555, 24'hAAAAAA, 23'h555555, 23'h2AAAAA, 16'h5555,
              24'hAAAAAA, 24'h555555, 23'h2AAAAA, 23'h555555, 16'hAAAA, 0);
    drain();

    tol_set = '{23'd4096, 23'h7FFFFF, 23'd1, 23'd0};
    for (int ph = 0; ph < 4; ph++) begin
      write_tol(tol_set[ph]);
      // a single quiet stretch, in phase 1 only, with neither side idling
      quiet_sink = (ph == 1);
      for (int n = 0; n < 275; n++) begin
        random_pair(ph == 1 && n < 100);
        // pause mid-phase until every result is back
        if (n == 137) drain();
      end
      quiet_sink = 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("oriented_rect_overlap_test_unit verification clean");
    end else begin
      $display("oriented_rect_overlap_test_unit verification failed");
    end
    $finish;
  end
endmodule
